/* design/pbrs_pkg.sv */
// Shared widths, constants and the divider stage word for the page boundary splitter.
package pbrs_pkg;

    localparam int PAGE_W   = 13;
    localparam int PAGE_NUM_W = 10;
    localparam int OFFSET_W = 16;
    localparam int COUNT_W  = 12;
    localparam int CPAGE_W  = 11;
    localparam int FIRST_W  = 12;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = OFFSET_W / DIV_STAGES;

    localparam int MAX_REQUEST_BYTES_DEF = 2048;

    localparam logic [PAGE_W-1:0] PAGE_MIN   = 13'd64;
    localparam logic [PAGE_W-1:0] PAGE_MAX   = 13'd4096;
    localparam logic [PAGE_W-1:0] PAGE_RESET = 13'd256;

    // Register index, as carried in paddr[2].
    localparam logic REG_PAGE_SIZE = 1'b0;

    // One request on its way through the divider pipeline.
    typedef struct packed {
        logic [PAGE_NUM_W-1:0] start_page;
        logic [OFFSET_W-1:0]   dividend;
        logic [FIRST_W-1:0]    rem;
        logic [OFFSET_W-1:0]   quot;
        logic [COUNT_W-1:0]    count;
    } t_div_word;

endpackage

/* design/pbrs_div_stage.sv */
// One stage of the pipelined restoring divider that splits the offset into page and remainder.
module pbrs_div_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  pbrs_pkg::t_div_word         i_word,
    input  logic [pbrs_pkg::PAGE_W-1:0] i_divisor,
    output logic                        o_valid,
    input  logic                        i_ready,
    output pbrs_pkg::t_div_word         o_word
);
    import pbrs_pkg::*;

    logic              r_valid;
    t_div_word         r_word;
    t_div_word         n_word;
    logic [PAGE_W-1:0] part;

    always_comb begin
        n_word = i_word;
        part   = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            part            = {n_word.rem, n_word.dividend[OFFSET_W-1]};
            n_word.dividend = {n_word.dividend[OFFSET_W-2:0], 1'b0};
            if (part >= i_divisor) begin
                n_word.rem  = FIRST_W'(part - i_divisor);
                n_word.quot = {n_word.quot[OFFSET_W-2:0], 1'b1};
            end else begin
                n_word.rem  = part[FIRST_W-1:0];
                n_word.quot = {n_word.quot[OFFSET_W-2:0], 1'b0};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

/* design/pbrs_chunker.sv */
// Chunk sequencer: walks a divided request page by page, a chunk per cycle unless stalled.
module pbrs_chunker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  pbrs_pkg::t_div_word          i_word,
    input  logic [pbrs_pkg::PAGE_W-1:0]  i_page,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pbrs_pkg::CPAGE_W-1:0] o_chunk_page,
    output logic [pbrs_pkg::FIRST_W-1:0] o_chunk_first_byte,
    output logic [pbrs_pkg::PAGE_W-1:0]  o_chunk_bytes,
    output logic                         o_last_chunk
);
    import pbrs_pkg::*;

    logic               r_busy;
    logic [CPAGE_W-1:0] r_page;
    logic [FIRST_W-1:0] r_first;
    logic [PAGE_W-1:0]  r_room;
    logic [COUNT_W-1:0] r_rem;

    logic               r_out_valid;
    logic [CPAGE_W-1:0] r_out_page;
    logic [FIRST_W-1:0] r_out_first;
    logic [PAGE_W-1:0]  r_out_bytes;
    logic               r_out_last;

    logic               load;
    logic               is_last;
    logic [PAGE_W-1:0]  take;
    logic               accept;

    // The room left in the current page is held, so a step is one compare and one subtract.
    assign load    = r_busy && (!r_out_valid || i_ready);
    assign is_last = {1'b0, r_rem} <= r_room;
    assign take    = is_last ? {1'b0, r_rem} : r_room;
    assign o_ready = !r_busy || (load && is_last);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // A request of zero bytes is taken and dropped without a transfer.
            if (accept) begin
                r_busy <= (i_word.count != '0);
            end else if (load && is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_page  <= r_page;
            r_out_first <= r_first;
            r_out_bytes <= take;
            r_out_last  <= is_last;
            r_page      <= r_page + 1'b1;
            r_first     <= '0;
            r_room      <= i_page;
            r_rem       <= r_rem - take[COUNT_W-1:0];
        end
        if (accept) begin
            r_page  <= CPAGE_W'({1'b0, i_word.start_page}) + i_word.quot[CPAGE_W-1:0];
            r_first <= i_word.rem;
            r_room  <= i_page - {1'b0, i_word.rem};
            r_rem   <= i_word.count;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_chunk_page       = r_out_page;
    assign o_chunk_first_byte = r_out_first;
    assign o_chunk_bytes      = r_out_bytes;
    assign o_last_chunk       = r_out_last;

    a_busy_has_bytes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem != '0))
        else $error("chunk sequencer busy with no bytes left");

    a_chunk_in_page : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_bytes != '0) &&
            (({2'b0, r_out_first} + {1'b0, r_out_bytes}) <= {1'b0, i_page})))
        else $error("chunk is empty or crosses a page boundary");

    a_rem_below_page : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ({1'b0, i_word.rem} < i_page))
        else $error("divider remainder not below page size");

endmodule

/* design/page_boundary_range_splitter.sv */
// Page boundary range splitter: a request enters a four-stage offset divider, then the chunk
// sequencer gives one chunk per cycle for each page touched while the output is not stalled;
// a zero-byte request is taken without a chunk. While the sequencer is busy, up to four further
// requests can enter the divider, one per cycle, before the input stalls. A request passes
// through the four divider stage registers and the sequencer's state registers before its
// first chunk is registered at the output. The page size register reads back as written;
// values below 64 act as 64 and above 4096 as 4096, and it may be written only while no
// request is in flight.
module page_boundary_range_splitter #(
    parameter int MAX_REQUEST_BYTES = pbrs_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pbrs_pkg::PAGE_NUM_W-1:0] i_start_page,
    input  logic [pbrs_pkg::OFFSET_W-1:0]   i_byte_offset,
    input  logic [pbrs_pkg::COUNT_W-1:0]    i_byte_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pbrs_pkg::CPAGE_W-1:0]    o_chunk_page,
    output logic [pbrs_pkg::FIRST_W-1:0]    o_chunk_first_byte,
    output logic [pbrs_pkg::PAGE_W-1:0]     o_chunk_bytes,
    output logic                            o_last_chunk,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pbrs_pkg::APB_AW-1:0]     paddr,
    input  logic [pbrs_pkg::APB_DW-1:0]     pwdata,
    output logic [pbrs_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import pbrs_pkg::*;

    localparam logic [16:0] MAX_BYTES = 17'(MAX_REQUEST_BYTES);

    logic [PAGE_W-1:0] r_page_size;
    logic [PAGE_W-1:0] r_eff_page;
    logic [PAGE_W-1:0] n_eff_page;
    logic              cfg_write;
    logic [COUNT_W-1:0] count_clamped;

    t_div_word stage_word  [0:DIV_STAGES];
    logic      stage_valid [0:DIV_STAGES];
    logic      stage_ready [0:DIV_STAGES];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        if (pwdata[PAGE_W-1:0] < PAGE_MIN) begin
            n_eff_page = PAGE_MIN;
        end else if (pwdata[PAGE_W-1:0] > PAGE_MAX) begin
            n_eff_page = PAGE_MAX;
        end else begin
            n_eff_page = pwdata[PAGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= PAGE_RESET;
            r_eff_page  <= PAGE_RESET;
        end else if (cfg_write && (paddr[2] == REG_PAGE_SIZE)) begin
            r_page_size <= pwdata[PAGE_W-1:0];
            r_eff_page  <= n_eff_page;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PAGE_SIZE: prdata = {{(APB_DW-PAGE_W){1'b0}}, r_page_size};
            default:       prdata = '0;
        endcase
    end

    assign count_clamped = ({5'b0, i_byte_count} > MAX_BYTES) ? MAX_BYTES[COUNT_W-1:0]
                                                              : i_byte_count;

    assign stage_valid[0]           = i_valid;
    assign o_ready                  = stage_ready[0];
    assign stage_word[0].start_page = i_start_page;
    assign stage_word[0].dividend   = i_byte_offset;
    assign stage_word[0].rem        = '0;
    assign stage_word[0].quot       = '0;
    assign stage_word[0].count      = count_clamped;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pbrs_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (stage_valid[g]),
            .o_ready   (stage_ready[g]),
            .i_word    (stage_word[g]),
            .i_divisor (r_eff_page),
            .o_valid   (stage_valid[g+1]),
            .i_ready   (stage_ready[g+1]),
            .o_word    (stage_word[g+1])
        );
    end

    pbrs_chunker u_chunker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (stage_valid[DIV_STAGES]),
        .o_ready            (stage_ready[DIV_STAGES]),
        .i_word             (stage_word[DIV_STAGES]),
        .i_page             (r_eff_page),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_chunk_page       (o_chunk_page),
        .o_chunk_first_byte (o_chunk_first_byte),
        .o_chunk_bytes      (o_chunk_bytes),
        .o_last_chunk       (o_last_chunk)
    );

endmodule

/* tb/tb_page_boundary_range_splitter.sv */
// Self-checking testbench for the page boundary range splitter: directed and random requests.
module tb_page_boundary_range_splitter;
    import pbrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_GAP        = 12;

    localparam logic [APB_AW-1:0] ADDR_PAGE_SIZE = {REG_PAGE_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED  = 3'd4;

    typedef struct packed {
        logic [CPAGE_W-1:0] page;
        logic [FIRST_W-1:0] first;
        logic [PAGE_W-1:0]  bytes;
        logic               last;
    } t_chunk;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [PAGE_NUM_W-1:0] i_start_page;
    logic [OFFSET_W-1:0]   i_byte_offset;
    logic [COUNT_W-1:0]    i_byte_count;
    logic                  o_valid;
    logic                  i_ready;
    logic [CPAGE_W-1:0]    o_chunk_page;
    logic [FIRST_W-1:0]    o_chunk_first_byte;
    logic [PAGE_W-1:0]     o_chunk_bytes;
    logic                  o_last_chunk;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    t_chunk            expected_chunks[$];
    logic [PAGE_W-1:0] page_size_shadow;
    int                fail_count;
    bit                idle_on;
    int                quiet_cycles;

    page_boundary_range_splitter i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_start_page       (i_start_page),
        .i_byte_offset      (i_byte_offset),
        .i_byte_count       (i_byte_count),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_chunk_page       (o_chunk_page),
        .o_chunk_first_byte (o_chunk_first_byte),
        .o_chunk_bytes      (o_chunk_bytes),
        .o_last_chunk       (o_last_chunk),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned effective_page_size();
        if (page_size_shadow < PAGE_MIN) return 32'(PAGE_MIN);
        if (page_size_shadow > PAGE_MAX) return 32'(PAGE_MAX);
        return 32'(page_size_shadow);
    endfunction

    // Works out every chunk that one accepted request gives and queues them in order.
    function automatic void predict_chunks(input logic [PAGE_NUM_W-1:0] start_page,
                                           input logic [OFFSET_W-1:0] byte_offset,
                                           input logic [COUNT_W-1:0] byte_count);
        int unsigned ps;
        int unsigned pos;
        int unsigned remaining;
        int unsigned first;
        int unsigned room;
        int unsigned take;
        t_chunk      c;
        ps = effective_page_size();
        pos = 32'(byte_offset);
        remaining = 32'(byte_count);
        if (remaining > MAX_REQUEST_BYTES_DEF) remaining = MAX_REQUEST_BYTES_DEF;
        while (remaining > 0) begin
            first = pos % ps;
            room = ps - first;
            take = (remaining < room) ? remaining : room;
            remaining -= take;
            c.page = CPAGE_W'(start_page + pos / ps);
            c.first = FIRST_W'(first);
            c.bytes = PAGE_W'(take);
            c.last = (remaining == 0);
            expected_chunks.push_back(c);
            pos += take;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : chunk_checker
        t_chunk exp_chunk;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chunks.size() == 0) begin
                $display("%0t: unexpected chunk expected none actual page %0d first %0d bytes %0d",
                         $time, o_chunk_page, o_chunk_first_byte, o_chunk_bytes);
                fail_count++;
            end else begin
                exp_chunk = expected_chunks.pop_front();
                check_field("chunk_page", 32'(exp_chunk.page), 32'(o_chunk_page));
                check_field("chunk_first_byte", 32'(exp_chunk.first), 32'(o_chunk_first_byte));
                check_field("chunk_bytes", 32'(exp_chunk.bytes), 32'(o_chunk_bytes));
                check_field("last_chunk", 32'(exp_chunk.last), 32'(o_last_chunk));
            end
        end
    end

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("page_boundary_range_splitter: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result side: a fresh stall length is drawn for every chunk transfer.
    initial begin : chunk_receiver
        int gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // Leaves i_valid high on return; the caller either sends again or drops it in the same step.
    task automatic send_request(input logic [PAGE_NUM_W-1:0] start_page,
                                input logic [OFFSET_W-1:0] byte_offset,
                                input logic [COUNT_W-1:0] byte_count);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_page <= start_page;
        i_byte_offset <= byte_offset;
        i_byte_count <= byte_count;
        do @(posedge i_clk); while (!o_ready);
        predict_chunks(start_page, byte_offset, byte_count);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_chunks.size() != 0);
    endtask

    // A zero-byte request gives no chunk, so allow the pipeline to empty after the last one.
    task automatic drain();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Ends with psel low after the access phase, so a following transfer starts cleanly.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_PAGE_SIZE) page_size_shadow = data[PAGE_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic check_page_size_readback();
        logic [APB_DW-1:0] read_val;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_PAGE_SIZE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        read_val = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (read_val !== APB_DW'(page_size_shadow)) begin
            $display("%0t: page_size read expected %0d actual %0d",
                     $time, page_size_shadow, read_val);
            fail_count++;
        end
    endtask

    // Upper bits of the write data are random; only the low bits belong to the register.
    task automatic set_page_size(input logic [PAGE_W-1:0] value);
        logic [APB_DW-1:0] data;
        drain();
        data = $urandom;
        data[PAGE_W-1:0] = value;
        apb_write(ADDR_PAGE_SIZE, data);
        check_page_size_readback();
    endtask

    task automatic send_random_request();
        int unsigned ps;
        int unsigned kind;
        int unsigned count;
        int unsigned span;
        logic [OFFSET_W-1:0] offset;
        ps = effective_page_size();
        kind = $urandom_range(0, 19);
        offset = OFFSET_W'($urandom);
        if (kind == 0) begin
            count = 0;
        end else if (kind <= 3) begin
            count = $urandom_range(0, (1 << COUNT_W) - 1);
        end else if (kind <= 7) begin
            // End exactly on a page boundary, unless the count is clamped.
            count = (ps - offset % ps) + ps * $urandom_range(0, 3);
            if (count > (1 << COUNT_W) - 1) count = (1 << COUNT_W) - 1;
        end else begin
            span = (2 * ps < 1024) ? 2 * ps : 1024;
            count = $urandom_range(1, span);
        end
        send_request(PAGE_NUM_W'($urandom), offset, COUNT_W'(count));
    endtask

    task automatic test_reset_page_size();
        idle_on = 1'b0;
        check_page_size_readback();
        send_request(10'd0, 16'd0, 12'd1);
        send_request(10'd1023, 16'd65535, 12'd4095);
        send_request(10'd0, 16'd0, 12'd256);
        send_request(10'd5, 16'd200, 12'd56);
        send_request(10'd5, 16'd200, 12'd57);
        send_request(10'd3, 16'd0, 12'd0);
        send_request(10'd7, 16'd0, 12'd2048);
        send_request(10'd7, 16'd10, 12'd2049);
    endtask

    task automatic test_page_wrap();
        set_page_size(PAGE_MIN);
        send_request(10'd1023, 16'd65535, 12'd2048);
        send_request(10'd1023, 16'd65472, 12'd2048);
        send_request(10'd512, 16'd63, 12'd1);
    endtask

    task automatic test_largest_page();
        set_page_size(PAGE_MAX);
        send_request(10'd1023, 16'd65535, 12'd4095);
        send_request(10'd0, 16'd4095, 12'd1);
        send_request(10'd9, 16'd4000, 12'd96);
    endtask

    task automatic test_out_of_range_page_size();
        set_page_size(13'd0);
        send_request(10'd100, 16'd1000, 12'd200);
        set_page_size(13'd63);
        send_request(10'd100, 16'd1000, 12'd200);
        set_page_size(13'd8191);
        send_request(10'd100, 16'd4090, 12'd2048);
        set_page_size(13'd4097);
        send_request(10'd100, 16'd4090, 12'd20);
    endtask

    task automatic test_unmapped_register();
        set_page_size(13'd100);
        drain();
        apb_write(ADDR_UNMAPPED, $urandom);
        check_page_size_readback();
        send_request(10'd1, 16'd199, 12'd300);
        send_request(10'd2, 16'd50, 12'd50);
    endtask

    task automatic test_random_phase(input logic [PAGE_W-1:0] value, input int n_items,
                                     input bit with_idle);
        set_page_size(value);
        idle_on = with_idle;
        for (int i = 0; i < n_items; i++) begin
            // Hold the sender back once until the block has handed out everything.
            if (i == n_items / 2) pause_until_drained();
            send_random_request();
        end
    endtask

    task automatic test_random();
        test_random_phase(PAGE_MIN, 17, 1'b1);
        test_random_phase(PAGE_MAX, 17, 1'b0);
        test_random_phase(PAGE_RESET, 17, 1'b1);
        test_random_phase(PAGE_W'($urandom_range(PAGE_MIN, PAGE_MAX)), 17, 1'b1);
        test_random_phase(PAGE_W'($urandom), 17, 1'b0);
        test_random_phase(PAGE_W'($urandom_range(PAGE_MIN, 300)), 17, 1'b1);
    endtask

    initial begin
        fail_count = 0;
        idle_on = 1'b0;
        quiet_cycles = 0;
        page_size_shadow = PAGE_RESET;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_start_page <= '0;
        i_byte_offset <= '0;
        i_byte_count <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_page_size();
        test_page_wrap();
        test_largest_page();
        test_out_of_range_page_size();
        test_unmapped_register();
        test_random();

        drain();
        if (fail_count == 0) begin
            $display("page_boundary_range_splitter: match");
        end else begin
            $display("page_boundary_range_splitter: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
design/pbrs_pkg.sv
design/pbrs_div_stage.sv
design/pbrs_chunker.sv
design/page_boundary_range_splitter.sv
tb/tb_page_boundary_range_splitter.sv
